### hdl/p4ag_pkg.sv
// Shared constants and types for the permuted 4D address generator.
`timescale 1ns / 1ps

package p4ag_pkg;

    // Width of the emitted element addresses.
    localparam int ADDR_W = 35;

    // Width of the configuration write data and of the register index.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // Width of the packed input and output stream data, padded to bytes.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 72;

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    // Register map.
    localparam t_cfg_index CFG_SOURCE_SHAPE   = 3'd0;
    localparam t_cfg_index CFG_SOURCE_STRIDES = 3'd1;
    localparam t_cfg_index CFG_DEST_STRIDES   = 3'd2;
    localparam t_cfg_index CFG_AXIS_ORDER     = 3'd3;
    localparam t_cfg_index CFG_SOURCE_BASE    = 3'd4;
    localparam t_cfg_index CFG_DEST_BASE      = 3'd5;

    // Identity axis order 0,1,2,3.
    localparam logic [7:0] AXIS_ORDER_RESET = 8'd228;

endpackage

### hdl/permute_4d_address_generator.sv
// Address generator for a strided, axis-permuted 4D tensor copy.
//
// Usage: program the six registers through the cfg channel while the block is
// idle, then send one transfer per address pair on the s_axis channel with
// tdata[0] (advance) set. Each such transfer yields one transfer on m_axis
// carrying the source (read) and destination (write) element addresses; tlast
// marks the final pair of the copy, after which the counters wrap to zero.
// A transfer with advance clear, or one taken while any permuted dimension is
// zero, yields no output; the latter also clears the counters.
// The pair passes through the index, multiplier and output registers before it
// is valid on m_axis.
// Throughput is one pair per cycle while m_axis keeps up: the counter step is a
// compare and an increment per dimension, then a multiplier and an adder stage.
// When m_axis stalls, the three stages fill and s_axis_tready then drops; it
// returns in the same cycle in which m_axis_tready returns.
// Reset clears the counters and the pipeline and loads the register defaults
// (all zero, identity axis order). The cfg channel is always ready.
`timescale 1ns / 1ps

module permute_4d_address_generator #(
    parameter int DIM_BITS  = 16,
    parameter int BASE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  p4ag_pkg::t_cfg_index                i_cfg_index,
    input  logic [p4ag_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [p4ag_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [0] advance, [7:1] zero
    // Output stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [p4ag_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // [34:0] read_address,
                                                               // [69:35] write_address,
                                                               // [71:70] zero
    output logic                                m_axis_tlast   // final_pair
);

    import p4ag_pkg::*;

    localparam int PACK_W = 4 * DIM_BITS;
    localparam int PROD_W = 2 * DIM_BITS;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_source_shape;
    logic [CFG_DATA_W-1:0] r_source_strides;
    logic [CFG_DATA_W-1:0] r_dest_strides;
    logic [7:0]            r_axis_order;
    logic [BASE_BITS-1:0]  r_source_base;
    logic [BASE_BITS-1:0]  r_dest_base;

    // Loop counters, dimension 3 innermost.
    logic [DIM_BITS-1:0] r_index [4];
    logic [DIM_BITS-1:0] n_index [4];

    // Stage 1: captured indices of the pair being generated.
    logic                r_s1_valid;
    logic [DIM_BITS-1:0] r_s1_index [4];
    logic                r_s1_last;

    // Stage 2: per-dimension offsets.
    logic                r_s2_valid;
    logic [PROD_W-1:0]   r_s2_rd_prod [4];
    logic [PROD_W-1:0]   r_s2_wr_prod [4];
    logic                r_s2_last;

    // Stage 3: output register.
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_rd;
    logic [ADDR_W-1:0]   r_out_wr;
    logic                r_out_last;

    logic [PACK_W-1:0]   w_shape_packed;
    logic [PACK_W-1:0]   w_src_stride_packed;
    logic [PACK_W-1:0]   w_dst_stride_packed;
    logic [DIM_BITS-1:0] w_shape_lane [4];
    logic [DIM_BITS-1:0] w_src_stride_lane [4];
    logic [DIM_BITS-1:0] w_dst_stride_lane [4];
    logic [DIM_BITS-1:0] w_shape [4];
    logic [DIM_BITS-1:0] w_src_stride [4];
    logic [1:0]          w_axis [4];
    logic [3:0]          w_wrap;
    logic [3:0]          w_carry;
    logic                w_zero_dim;
    logic                w_last;
    logic                w_accept;
    logic                w_issue;
    logic                w_ready_out;
    logic                w_ready_s2;
    logic                w_ready_s1;
    logic [ADDR_W-1:0]   n_out_rd;
    logic [ADDR_W-1:0]   n_out_wr;

    // Configuration writes are taken in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_shape   <= '0;
            r_source_strides <= '0;
            r_dest_strides   <= '0;
            r_axis_order     <= AXIS_ORDER_RESET;
            r_source_base    <= '0;
            r_dest_base      <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SOURCE_SHAPE:   r_source_shape   <= i_cfg_data;
                CFG_SOURCE_STRIDES: r_source_strides <= i_cfg_data;
                CFG_DEST_STRIDES:   r_dest_strides   <= i_cfg_data;
                CFG_AXIS_ORDER:     r_axis_order     <= i_cfg_data[7:0];
                CFG_SOURCE_BASE:    r_source_base    <= i_cfg_data[BASE_BITS-1:0];
                CFG_DEST_BASE:      r_dest_base      <= i_cfg_data[BASE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Split the packed registers into lanes; lanes past bit 63 read as zero.
    assign w_shape_packed      = PACK_W'(r_source_shape);
    assign w_src_stride_packed = PACK_W'(r_source_strides);
    assign w_dst_stride_packed = PACK_W'(r_dest_strides);

    always_comb begin
        for (int d = 0; d < 4; d++) begin
            w_shape_lane[d]      = w_shape_packed[d*DIM_BITS +: DIM_BITS];
            w_src_stride_lane[d] = w_src_stride_packed[d*DIM_BITS +: DIM_BITS];
            w_dst_stride_lane[d] = w_dst_stride_packed[d*DIM_BITS +: DIM_BITS];
            w_axis[d]            = r_axis_order[2*d +: 2];
            w_shape[d]           = w_shape_lane[w_axis[d]];
            w_src_stride[d]      = w_src_stride_lane[w_axis[d]];
        end
    end

    // Counter step: a dimension wraps when at or past its last value, and the
    // carry ripples outward from the innermost dimension.
    always_comb begin
        w_zero_dim = 1'b0;
        for (int d = 0; d < 4; d++) begin
            w_zero_dim = w_zero_dim | (w_shape[d] == '0);
            w_wrap[d]  = (r_index[d] >= w_shape[d] - DIM_BITS'(1));
        end
        w_last     = &w_wrap;
        w_carry[3] = 1'b1;
        for (int d = 2; d >= 0; d--) begin
            w_carry[d] = w_carry[d+1] & w_wrap[d+1];
        end
        for (int d = 0; d < 4; d++) begin
            if (w_zero_dim) begin
                n_index[d] = '0;
            end else if (!w_carry[d]) begin
                n_index[d] = r_index[d];
            end else if (w_wrap[d]) begin
                n_index[d] = '0;
            end else begin
                n_index[d] = r_index[d] + DIM_BITS'(1);
            end
        end
    end

    // Ready chain: a stage may load when it is empty or its successor loads.
    assign w_ready_out   = !r_out_valid || m_axis_tready;
    assign w_ready_s2    = !r_s2_valid || w_ready_out;
    assign w_ready_s1    = !r_s1_valid || w_ready_s2;
    assign s_axis_tready = w_ready_s1;

    assign w_accept = s_axis_tvalid && s_axis_tready && s_axis_tdata[0];
    assign w_issue  = w_accept && !w_zero_dim;

    // Counters step on every accepted tick that asks for a pair, or clear when a permuted dimension is zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < 4; d++) begin
                r_index[d] <= '0;
            end
        end else if (w_accept) begin
            for (int d = 0; d < 4; d++) begin
                r_index[d] <= n_index[d];
            end
        end
    end

    // Stage 1 control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_ready_s1) begin
            r_s1_valid <= w_issue;
        end
    end

    // Stage 1 payload: indices and last flag of the issued pair.
    always_ff @(posedge i_clk) begin
        if (w_ready_s1 && w_issue) begin
            for (int d = 0; d < 4; d++) begin
                r_s1_index[d] <= r_index[d];
            end
            r_s1_last <= w_last;
        end
    end

    // Stage 2 control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_ready_s2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage 2 payload: index times stride for each dimension.
    always_ff @(posedge i_clk) begin
        if (w_ready_s2 && r_s1_valid) begin
            for (int d = 0; d < 4; d++) begin
                r_s2_rd_prod[d] <= PROD_W'(r_s1_index[d]) * PROD_W'(w_src_stride[d]);
                r_s2_wr_prod[d] <= PROD_W'(r_s1_index[d]) * PROD_W'(w_dst_stride_lane[d]);
            end
            r_s2_last <= r_s1_last;
        end
    end

    // Address sums, taken modulo the address width.
    always_comb begin
        n_out_rd = ADDR_W'(r_source_base);
        n_out_wr = ADDR_W'(r_dest_base);
        for (int d = 0; d < 4; d++) begin
            n_out_rd = n_out_rd + ADDR_W'(r_s2_rd_prod[d]);
            n_out_wr = n_out_wr + ADDR_W'(r_s2_wr_prod[d]);
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready_out) begin
            r_out_valid <= r_s2_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_ready_out && r_s2_valid) begin
            r_out_rd   <= n_out_rd;
            r_out_wr   <= n_out_wr;
            r_out_last <= r_s2_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - 2*ADDR_W){1'b0}}, r_out_wr, r_out_rd};
    assign m_axis_tlast  = r_out_last;

endmodule

### test/permute_4d_address_generator_test.sv
// Self-checking testbench for the permuted 4D address generator.
`timescale 1ns / 1ps

module permute_4d_address_generator_test;
    import p4ag_pkg::*;

    // Register indexes past the end of the map; writes to them must be ignored.
    localparam t_cfg_index CFG_SPARE_LO = 3'd6;
    localparam t_cfg_index CFG_SPARE_HI = 3'd7;

    // Number of random input transfers.
    localparam int RANDOM_TICKS = 1350;

    typedef struct packed {
        logic [ADDR_W-1:0] rd;
        logic [ADDR_W-1:0] wr;
        logic              last;
    } t_addr_pair;

    typedef enum {ROW_WRITE, ROW_TICK} t_row_kind;

    // One row of the directed sequence: a register write or a tick.
    typedef struct {
        t_row_kind  kind;
        t_cfg_index idx;
        logic [63:0] data;
        bit         typed;
        t_addr_pair want;
    } t_dir_row;

    typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    t_cfg_index             i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tlast;

    // Shadow copy of the registers and the loop counters.
    logic [63:0] cfg_shape      = '0;
    logic [63:0] cfg_src_stride = '0;
    logic [63:0] cfg_dst_stride = '0;
    logic [7:0]  cfg_axis       = AXIS_ORDER_RESET;
    logic [31:0] cfg_src_base   = '0;
    logic [31:0] cfg_dst_base   = '0;
    logic [15:0] loop_idx [4]   = '{default: '0};

    t_addr_pair pending_pairs [$];
    t_dir_row   dir_tab [$];
    int         mismatch_cnt = 0;

    permute_4d_address_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Works out the address pair for one advancing tick and steps the counters.
    // Returns 0 when a permuted dimension is zero; the counters are cleared then.
    function automatic bit next_address_pair(output t_addr_pair pair);
        logic [15:0]       dim [4];
        logic [ADDR_W-1:0] rd;
        logic [ADDR_W-1:0] wr;
        bit                last;
        bit                stepped;
        int                ax;
        pair = '0;
        for (int d = 0; d < 4; d++) begin
            ax = int'(cfg_axis[2*d +: 2]);
            dim[d] = cfg_shape[16*ax +: 16];
        end
        if (dim[0] == 0 || dim[1] == 0 || dim[2] == 0 || dim[3] == 0) begin
            for (int d = 0; d < 4; d++) loop_idx[d] = '0;
            return 1'b0;
        end
        rd = ADDR_W'(cfg_src_base);
        wr = ADDR_W'(cfg_dst_base);
        last = 1'b1;
        for (int d = 0; d < 4; d++) begin
            ax = int'(cfg_axis[2*d +: 2]);
            rd += ADDR_W'(loop_idx[d]) * ADDR_W'(cfg_src_stride[16*ax +: 16]);
            wr += ADDR_W'(loop_idx[d]) * ADDR_W'(cfg_dst_stride[16*d +: 16]);
            if (loop_idx[d] < dim[d] - 16'd1) last = 1'b0;
        end
        pair.rd = rd;
        pair.wr = wr;
        pair.last = last;
        // A counter at or beyond its last value wraps; the innermost steps first.
        stepped = 1'b0;
        for (int k = 3; k >= 0; k--) begin
            if (!stepped) begin
                if (loop_idx[k] >= dim[k] - 16'd1) begin
                    loop_idx[k] = '0;
                end else begin
                    loop_idx[k] = loop_idx[k] + 16'd1;
                    stepped = 1'b1;
                end
            end
        end
        return 1'b1;
    endfunction

    // Random sizes lean small so that copies finish within a phase.
    function automatic logic [15:0] pick_size(input bit tiny);
        int r;
        r = $urandom_range(0, 99);
        if (tiny) return 16'($urandom_range(1, 2));
        if (r < 5) return 16'd0;
        if (r < 10) return 16'hFFFF;
        if (r < 15) return 16'($urandom);
        if (r < 30) return 16'($urandom_range(5, 9));
        return 16'($urandom_range(1, 4));
    endfunction

    function automatic logic [63:0] pick_strides();
        logic [63:0] v;
        int          r;
        for (int d = 0; d < 4; d++) begin
            r = $urandom_range(0, 99);
            if (r < 15) v[16*d +: 16] = 16'd0;
            else if (r < 30) v[16*d +: 16] = 16'hFFFF;
            else v[16*d +: 16] = 16'($urandom);
        end
        return v;
    endfunction

    function automatic logic [63:0] pick_base();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 64'd0;
        if (r < 30) return '1;
        return {$urandom, $urandom};
    endfunction

    // Register write; the shadow copy follows at the accepting edge.
    task automatic write_reg(input t_cfg_index idx, input logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SOURCE_SHAPE:   cfg_shape = value;
            CFG_SOURCE_STRIDES: cfg_src_stride = value;
            CFG_DEST_STRIDES:   cfg_dst_stride = value;
            CFG_AXIS_ORDER:     cfg_axis = value[7:0];
            CFG_SOURCE_BASE:    cfg_src_base = value[31:0];
            CFG_DEST_BASE:      cfg_dst_base = value[31:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One input transfer. A typed expectation replaces the predicted one.
    task automatic send_tick(input bit adv, input bit typed, input t_addr_pair want);
        t_addr_pair pair;
        bit         got;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(adv);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (adv) begin
            got = next_address_pair(pair);
            if (got || typed) pending_pairs.push_back(typed ? want : pair);
        end
    endtask

    // Stops sending, waits for every expected pair and lets the pipeline empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Receiver: ready pattern switches to a randomly chosen mode whenever its random run length runs out.
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_LIGHT:  m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:  m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   m_axis_tready <= (rx_tick % 7 < 4);
        endcase
    end

    // Output checker: each transfer against the oldest expected pair.
    always @(posedge i_clk) begin
        t_addr_pair want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pairs.size() == 0) begin
                $error("unexpected transfer: read_address=%0h write_address=%0h final_pair=%0b",
                       m_axis_tdata[34:0], m_axis_tdata[69:35], m_axis_tlast);
                mismatch_cnt++;
            end else begin
                want = pending_pairs.pop_front();
                if (m_axis_tdata[34:0] !== want.rd) begin
                    $error("read_address: expected %0h, got %0h", want.rd, m_axis_tdata[34:0]);
                    mismatch_cnt++;
                end
                if (m_axis_tdata[69:35] !== want.wr) begin
                    $error("write_address: expected %0h, got %0h", want.wr,
                           m_axis_tdata[69:35]);
                    mismatch_cnt++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("final_pair: expected %0b, got %0b", want.last, m_axis_tlast);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Stimulus: directed table first, then random phases.
    initial begin
        int         rand_ticks;
        int         phase_len;
        int         burst_left;
        int         gap;
        int         r;
        bit         adv;
        bit         tiny;
        bit         steady;
        logic [63:0] v;

        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_SOURCE_SHAPE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;

        // After reset every dimension is zero, so nothing comes out.
        dir_tab.push_back('{ROW_TICK, CFG_SOURCE_SHAPE, 64'd1, 1'b0, '0});
        dir_tab.push_back('{ROW_TICK, CFG_SOURCE_SHAPE, 64'd0, 1'b0, '0});
        // A single-element copy with zero strides and bases.
        dir_tab.push_back('{ROW_WRITE, CFG_SOURCE_SHAPE, 64'h0001_0001_0001_0001, 1'b0, '0});
        dir_tab.push_back('{ROW_TICK, CFG_SOURCE_SHAPE, 64'd1, 1'b1,
                            '{35'd0, 35'd0, 1'b1}});
        // Largest bases and strides over a 2x2x2x2 copy, walked to the end.
        dir_tab.push_back('{ROW_WRITE, CFG_SOURCE_BASE, '1, 1'b0, '0});
        dir_tab.push_back('{ROW_WRITE, CFG_DEST_BASE, '1, 1'b0, '0});
        dir_tab.push_back('{ROW_WRITE, CFG_SOURCE_STRIDES, '1, 1'b0, '0});
        dir_tab.push_back('{ROW_WRITE, CFG_DEST_STRIDES, '1, 1'b0, '0});
        dir_tab.push_back('{ROW_WRITE, CFG_SOURCE_SHAPE, 64'h0002_0002_0002_0002, 1'b0, '0});
        dir_tab.push_back('{ROW_TICK, CFG_SOURCE_SHAPE, 64'd1, 1'b1,
                            '{35'h0_FFFF_FFFF, 35'h0_FFFF_FFFF, 1'b0}});
        for (int k = 0; k < 14; k++)
            dir_tab.push_back('{ROW_TICK, CFG_SOURCE_SHAPE, 64'd1, 1'b0, '0});
        dir_tab.push_back('{ROW_TICK, CFG_SOURCE_SHAPE, 64'd1, 1'b1,
                            '{35'h1_0003_FFFB, 35'h1_0003_FFFB, 1'b1}});
        // Reversed axis order over unequal sizes.
        dir_tab.push_back('{ROW_WRITE, CFG_AXIS_ORDER, 64'h1B, 1'b0, '0});
        dir_tab.push_back('{ROW_WRITE, CFG_SOURCE_SHAPE, 64'h0004_0003_0002_0001, 1'b0, '0});
        dir_tab.push_back('{ROW_TICK, CFG_SOURCE_SHAPE, 64'd1, 1'b0, '0});
        dir_tab.push_back('{ROW_TICK, CFG_SOURCE_SHAPE, 64'd1, 1'b0, '0});
        // A selected zero dimension gives nothing and clears the counters.
        dir_tab.push_back('{ROW_WRITE, CFG_SOURCE_SHAPE, 64'h0004_0003_0002_0000, 1'b0, '0});
        dir_tab.push_back('{ROW_TICK, CFG_SOURCE_SHAPE, 64'd1, 1'b0, '0});
        // Repeated axes: every entry picks dimension 3, so the zero is never seen.
        dir_tab.push_back('{ROW_WRITE, CFG_AXIS_ORDER, 64'hFF, 1'b0, '0});
        dir_tab.push_back('{ROW_TICK, CFG_SOURCE_SHAPE, 64'd1, 1'b0, '0});
        dir_tab.push_back('{ROW_TICK, CFG_SOURCE_SHAPE, 64'd1, 1'b0, '0});
        // Writes past the register map change nothing.
        dir_tab.push_back('{ROW_WRITE, CFG_SPARE_LO, '1, 1'b0, '0});
        dir_tab.push_back('{ROW_WRITE, CFG_SPARE_HI, '1, 1'b0, '0});
        dir_tab.push_back('{ROW_TICK, CFG_SOURCE_SHAPE, 64'd1, 1'b0, '0});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_WRITE) begin
                settle();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                send_tick(dir_tab[i].data[0], dir_tab[i].typed, dir_tab[i].want);
            end
        end

        // Random phases; counters carry over, so shrinking a shape mid-copy
        // leaves a counter past its size.
        rand_ticks = 0;
        while (rand_ticks < RANDOM_TICKS) begin
            settle();
            tiny = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) begin
                for (int d = 0; d < 4; d++) v[16*d +: 16] = pick_size(tiny);
                write_reg(CFG_SOURCE_SHAPE, v);
            end
            if ($urandom_range(0, 1) != 0) write_reg(CFG_SOURCE_STRIDES, pick_strides());
            if ($urandom_range(0, 1) != 0) write_reg(CFG_DEST_STRIDES, pick_strides());
            if ($urandom_range(0, 4) < 3) begin
                r = $urandom_range(0, 3);
                if (r == 0) v = 64'(AXIS_ORDER_RESET);
                else if (r == 1) v = 64'h1B;
                else v = {$urandom, $urandom};
                write_reg(CFG_AXIS_ORDER, v);
            end
            if ($urandom_range(0, 9) < 3) write_reg(CFG_SOURCE_BASE, pick_base());
            if ($urandom_range(0, 9) < 3) write_reg(CFG_DEST_BASE, pick_base());
            if ($urandom_range(0, 9) == 0)
                write_reg(t_cfg_index'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                          {$urandom, $urandom});

            // Bursts of transfers with random gaps; some phases never pause.
            steady = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(20, 120);
            burst_left = $urandom_range(1, 24);
            for (int n = 0; n < phase_len && rand_ticks < RANDOM_TICKS; n++) begin
                adv = ($urandom_range(0, 9) != 0);
                send_tick(adv, 1'b0, '0);
                rand_ticks++;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap != 0) begin
                        s_axis_tvalid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
        end

        settle();
        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake or a missing result.
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
